// File: rtl/core/linear_interp_resample_mixer_core_assert.svh
// Assertion macros for the resampling mixer core; they use clk and arst_n from the module.
`ifndef LINEAR_INTERP_RESAMPLE_MIXER_CORE_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLE_MIXER_CORE_ASSERT_SVH

// Same-cycle implication.
`define LIRM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication after a fixed number of cycles.
`define LIRM_ASSERT_DLY(lbl, ante, n, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

// File: rtl/core/lirm_pkg.sv
// Shared types and constants of the resampling mixer core.
package lirm_pkg;

	localparam int SOURCE_DEPTH = 4096;
	localparam int SAMPLE_BITS  = 16;
	localparam int ADDR_W       = $clog2(SOURCE_DEPTH);
	localparam int COUNT_W      = 13;
	localparam int STEP_W       = 32;
	localparam int INDEX_W      = 16;
	localparam int FRAC_W       = 16;
	localparam int POS_W        = STEP_W + INDEX_W;
	localparam int IPART_W      = POS_W - FRAC_W;
	localparam int CFG_DATA_W   = 32;
	localparam logic [IPART_W-1:0] SOURCE_DEPTH_W = IPART_W'(SOURCE_DEPTH);
	localparam int SAMPLE_MAX   = (2 ** (SAMPLE_BITS - 1)) - 1;
	localparam int SAMPLE_MIN   = -SAMPLE_MAX - 1;

	typedef enum logic {
		MODE_LOAD    = 1'b0,
		MODE_COMPUTE = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		REG_POSITION_STEP = 2'd0,
		REG_VALID_COUNT   = 2'd1,
		REG_STORED_COUNT  = 2'd2,
		REG_MIX_GAIN      = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		mode_t              mode;
		logic [11:0]        source_address;
		logic signed [15:0] sample_value;
		logic [15:0]        output_index;
		logic signed [15:0] existing_value;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] mixed_value;
		logic               beyond_source;
		logic               saturated;
	} rsp_t;

	typedef struct packed {
		logic                          wr_en;
		logic [ADDR_W-1:0]             wr_addr;
		logic signed [SAMPLE_BITS-1:0] wr_data;
		logic [ADDR_W-1:0]             rd_addr0;
		logic [ADDR_W-1:0]             rd_addr1;
	} mem_req_t;

	typedef struct packed {
		logic               cmp;
		logic               beyond;
		logic               has_next;
		logic [FRAC_W-1:0]  frac;
		logic signed [15:0] existing;
	} pipe_ctl_t;

endpackage

// File: rtl/core/lirm_addr.sv
// Position multiply and source address generation stage.
module lirm_addr (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  lirm_pkg::cmd_t               cmd,
	input  logic [lirm_pkg::STEP_W-1:0]  position_step,
	input  logic [lirm_pkg::COUNT_W-1:0] valid_count,
	input  logic [lirm_pkg::COUNT_W-1:0] stored_count,
	output lirm_pkg::mem_req_t           mem_req,
	output lirm_pkg::pipe_ctl_t          ctl
);
	import lirm_pkg::*;

	logic                  vld_s1;
	mode_t                 mode_s1;
	logic [POS_W-1:0]      pos_s1;
	logic [11:0]           saddr_s1;
	logic signed [15:0]    sval_s1;
	logic signed [15:0]    exist_s1;

	logic [IPART_W-1:0]    ipart;
	logic [IPART_W:0]      inext;
	logic [IPART_W-1:0]    nbound;
	logic [IPART_W-1:0]    limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= cmd.mode;
			pos_s1   <= POS_W'(cmd.output_index) * POS_W'(position_step);
			saddr_s1 <= cmd.source_address;
			sval_s1  <= cmd.sample_value;
			exist_s1 <= cmd.existing_value;
		end
	end

	always_comb begin
		ipart  = pos_s1[POS_W-1:FRAC_W];
		inext  = {1'b0, ipart} + (IPART_W+1)'(1);
		nbound = (IPART_W'(stored_count) > SOURCE_DEPTH_W) ? SOURCE_DEPTH_W
			: IPART_W'(stored_count);
		limit  = (IPART_W'(valid_count) > nbound) ? nbound : IPART_W'(valid_count);
	end

	always_comb begin
		mem_req.wr_en    = vld_s1 && (mode_s1 == MODE_LOAD)
			&& (IPART_W'(saddr_s1) < SOURCE_DEPTH_W);
		mem_req.wr_addr  = ADDR_W'(saddr_s1);
		mem_req.wr_data  = SAMPLE_BITS'(sval_s1);
		mem_req.rd_addr0 = ipart[ADDR_W-1:0];
		mem_req.rd_addr1 = inext[ADDR_W-1:0];

		ctl.cmp      = vld_s1 && (mode_s1 == MODE_COMPUTE);
		ctl.beyond   = (ipart >= limit);
		ctl.has_next = (inext < {1'b0, nbound});
		ctl.frac     = pos_s1[FRAC_W-1:0];
		ctl.existing = exist_s1;
	end

endmodule

// File: rtl/core/lirm_store.sv
// Source sample memory: one write port, two registered read ports.
module lirm_store (
	input  logic                                  clk,
	input  lirm_pkg::mem_req_t                    mem_req,
	output logic signed [lirm_pkg::SAMPLE_BITS-1:0] rd_data0,
	output logic signed [lirm_pkg::SAMPLE_BITS-1:0] rd_data1
);
	import lirm_pkg::*;

	logic signed [SAMPLE_BITS-1:0] mem [SOURCE_DEPTH];

	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem[mem_req.wr_addr] <= mem_req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data0 <= mem[mem_req.rd_addr0];
		rd_data1 <= mem[mem_req.rd_addr1];
	end

endmodule

// File: rtl/core/lirm_datapath.sv
// Interpolation, gain and saturating mix pipeline.
module lirm_datapath (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  lirm_pkg::pipe_ctl_t                     ctl,
	input  logic signed [lirm_pkg::SAMPLE_BITS-1:0] rd_data0,
	input  logic signed [lirm_pkg::SAMPLE_BITS-1:0] rd_data1,
	input  logic signed [15:0]                      mix_gain,
	output logic                                    done,
	output lirm_pkg::rsp_t                          rsp
);
	import lirm_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int SW = SB + 17;
	localparam logic signed [SW-1:0] ROUND_HALF = SW'(64'sd8192);
	localparam logic signed [SW-1:0] S_MAX = SW'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] S_MIN = -S_MAX - SW'(64'sd1);

	pipe_ctl_t               ctl_s2;
	logic                    vld_s2, vld_s3, vld_s4, done_q;

	logic signed [SB:0]      diff;
	logic signed [SB+17:0]   prod_c;

	logic signed [SB+17:0]   prod_s3;
	logic signed [SB-1:0]    a_s3;
	logic                    has_next_s3, beyond_s3;
	logic signed [15:0]      exist_s3;

	logic signed [SB+17:0]   prod_sh;
	logic signed [SB+1:0]    v_wide;
	logic signed [SB-1:0]    v;
	logic signed [SB+15:0]   gp_c;

	logic signed [SB+15:0]   gp_s4;
	logic                    beyond_s4;
	logic signed [15:0]      exist_s4;

	logic signed [SW-1:0]    rnd, g, sum, clip;
	logic                    clipped;

	rsp_t                    rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s2 <= ctl.cmp;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			done_q <= vld_s4;
		end
	end

	always_comb begin
		diff   = (SB+1)'(rd_data1) - (SB+1)'(rd_data0);
		prod_c = diff * $signed({1'b0, ctl_s2.frac});
	end

	always_comb begin
		prod_sh = prod_s3 >>> FRAC_W;
		v_wide  = (SB+2)'(a_s3) + (SB+2)'(prod_sh);
		v       = has_next_s3 ? v_wide[SB-1:0] : a_s3;
		gp_c    = v * mix_gain;
	end

	always_comb begin
		rnd     = SW'(gp_s4) + ROUND_HALF;
		g       = rnd >>> 14;
		sum     = SW'(exist_s4) + g;
		clipped = (sum > S_MAX) || (sum < S_MIN);
		if (sum > S_MAX) begin
			clip = S_MAX;
		end else if (sum < S_MIN) begin
			clip = S_MIN;
		end else begin
			clip = sum;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s2 <= ctl;

		prod_s3     <= prod_c;
		a_s3        <= rd_data0;
		has_next_s3 <= ctl_s2.has_next;
		beyond_s3   <= ctl_s2.beyond;
		exist_s3    <= ctl_s2.existing;

		gp_s4     <= gp_c;
		beyond_s4 <= beyond_s3;
		exist_s4  <= exist_s3;

		if (vld_s4) begin
			rsp_q.beyond_source <= beyond_s4;
			rsp_q.saturated     <= !beyond_s4 && clipped;
			rsp_q.mixed_value   <= beyond_s4 ? exist_s4 : 16'(clip);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// File: rtl/core/linear_interp_resample_mixer_core.sv
// Linear interpolation resampler and mixer, top level.
// Throughput: one transaction per cycle, load or compute in any mix; busy is always low.
// A compute transaction passes registers s1, s2, s3 and s4 and the done register before done.
// The two source reads per compute come from the dual read port source memory in the same cycle.
// Reset clears pipeline valid bits and returns configuration to its defaults; memory is kept.
// A load is seen by every compute accepted after it.
`include "linear_interp_resample_mixer_core_assert.svh"

module linear_interp_resample_mixer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  lirm_pkg::cmd_t                  cmd,
	output logic                            done,
	output lirm_pkg::rsp_t                  rsp,
	input  logic                            cfg_write,
	input  lirm_pkg::cfg_reg_t              cfg_index,
	input  logic [lirm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lirm_pkg::*;

	logic [STEP_W-1:0]             step_q;
	logic [COUNT_W-1:0]            valid_q;
	logic [COUNT_W-1:0]            stored_q;
	logic signed [15:0]            gain_q;

	logic                          accept;
	logic                          cmp_acc;
	mem_req_t                      mem_req;
	pipe_ctl_t                     ctl;
	logic signed [SAMPLE_BITS-1:0] rd_data0, rd_data1;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign cmp_acc = accept && (cmd.mode == MODE_COMPUTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= STEP_W'(65536);
			valid_q  <= '0;
			stored_q <= '0;
			gain_q   <= 16'sd16384;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_POSITION_STEP: step_q   <= cfg_data[STEP_W-1:0];
				REG_VALID_COUNT:   valid_q  <= cfg_data[COUNT_W-1:0];
				REG_STORED_COUNT:  stored_q <= cfg_data[COUNT_W-1:0];
				REG_MIX_GAIN:      gain_q   <= signed'(cfg_data[15:0]);
				default:           ;
			endcase
		end
	end

	lirm_addr u_addr (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.cmd           (cmd),
		.position_step (step_q),
		.valid_count   (valid_q),
		.stored_count  (stored_q),
		.mem_req       (mem_req),
		.ctl           (ctl)
	);

	lirm_store u_store (
		.clk      (clk),
		.mem_req  (mem_req),
		.rd_data0 (rd_data0),
		.rd_data1 (rd_data1)
	);

	lirm_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.rd_data0 (rd_data0),
		.rd_data1 (rd_data1),
		.mix_gain (gain_q),
		.done     (done),
		.rsp      (rsp)
	);

	`LIRM_ASSERT_DLY(a_cmp_gives_done, cmp_acc, 5, done, "compute transaction lost")
	`LIRM_ASSERT_IMP(a_done_has_cmp, done, $past(cmp_acc, 5), "done without compute transaction")
	`LIRM_ASSERT_IMP(a_beyond_no_sat, done && rsp.beyond_source, !rsp.saturated,
		"beyond source result flagged saturated")
	`LIRM_ASSERT_IMP(a_sat_at_rail, done && rsp.saturated,
		(rsp.mixed_value == 16'(SAMPLE_MAX)) || (rsp.mixed_value == 16'(SAMPLE_MIN)),
		"saturated result not at a rail")

endmodule

// File: bench/tb_linear_interp_resample_mixer_core.sv
// Self-checking testbench for the resampling mixer core, results checked in order.
module tb_linear_interp_resample_mixer_core;
	import lirm_pkg::*;

	localparam int WATCHDOG_CYCLES = 2000;
	localparam int SETTLE_CYCLES   = 8;

	class mix_scoreboard;
		logic [31:0]        pos_step;
		logic [12:0]        valid_cnt;
		logic [12:0]        stored_cnt;
		logic signed [15:0] gain;
		logic signed [15:0] src_mem [SOURCE_DEPTH];
		bit                 written [SOURCE_DEPTH];
		rsp_t               expected_mix[$];
		int                 errors, n_loads, n_computes, n_beyond, n_clipped;

		function new();
			pos_step   = 32'h0001_0000;
			valid_cnt  = '0;
			stored_cnt = '0;
			gain       = 16'sd16384;
		endfunction

		function void set_reg(cfg_reg_t r, logic [31:0] d);
			case (r)
				REG_POSITION_STEP: pos_step = d;
				REG_VALID_COUNT: valid_cnt = d[12:0];
				REG_STORED_COUNT: stored_cnt = d[12:0];
				REG_MIX_GAIN: gain = d[15:0];
			endcase
		endfunction

		function longint neighbour_bound();
			return (stored_cnt > SOURCE_DEPTH) ? SOURCE_DEPTH : longint'(stored_cnt);
		endfunction

		function longint usable_limit();
			longint nb;
			nb = neighbour_bound();
			return (valid_cnt > nb) ? nb : longint'(valid_cnt);
		endfunction

		function longint unsigned int_pos(logic [15:0] idx);
			longint unsigned p;
			p = longint'(idx) * longint'(pos_step);
			return p >> FRAC_W;
		endfunction

		// never touch a store entry that has not been loaded
		function bit reads_written(logic [15:0] idx);
			longint unsigned ip;
			ip = int_pos(idx);
			if (ip >= usable_limit())
				return 1;
			if (!written[ip])
				return 0;
			if (ip + 1 < neighbour_bound() && !written[ip + 1])
				return 0;
			return 1;
		endfunction

		function logic [15:0] pick_index();
			longint unsigned tgt, cand;
			logic [15:0] idx;
			for (int tries = 0; tries < 16; tries++) begin
				if ($urandom_range(0, 3) == 0 || usable_limit() == 0 || pos_step == 0) begin
					idx = 16'($urandom);
				end else begin
					tgt  = $urandom_range(0, int'(usable_limit()));
					cand = ((tgt << FRAC_W) + $urandom_range(0, 65535)) / pos_step;
					idx  = (cand > 65535) ? 16'($urandom) : 16'(cand);
				end
				if (reads_written(idx))
					return idx;
			end
			return '0;
		endfunction

		function rsp_t mix_sample(cmd_t c);
			rsp_t            r;
			longint unsigned p, ip;
			longint          fr, a, b, v, g, s;
			p  = longint'(c.output_index) * longint'(pos_step);
			ip = p >> FRAC_W;
			fr = longint'(p & 64'hFFFF);
			if (ip >= usable_limit()) begin
				r.mixed_value   = c.existing_value;
				r.beyond_source = 1'b1;
				r.saturated     = 1'b0;
				return r;
			end
			a = src_mem[ip];
			v = a;
			if (ip + 1 < neighbour_bound()) begin
				b = src_mem[ip + 1];
				v = a + (((b - a) * fr) >>> FRAC_W);
			end
			g = (v * longint'(gain) + 8192) >>> 14;
			s = longint'(c.existing_value) + g;
			r.saturated = 1'b0;
			if (s > SAMPLE_MAX) begin
				s = SAMPLE_MAX;
				r.saturated = 1'b1;
			end else if (s < SAMPLE_MIN) begin
				s = SAMPLE_MIN;
				r.saturated = 1'b1;
			end
			r.mixed_value   = 16'(s);
			r.beyond_source = 1'b0;
			return r;
		endfunction

		function void note_cmd(cmd_t c);
			rsp_t r;
			if (c.mode == MODE_LOAD) begin
				src_mem[c.source_address] = c.sample_value;
				written[c.source_address] = 1'b1;
				n_loads++;
			end else begin
				r = mix_sample(c);
				expected_mix.push_back(r);
				n_computes++;
				n_beyond  += r.beyond_source;
				n_clipped += r.saturated;
			end
		endfunction

		function void check_rsp(rsp_t got);
			rsp_t want;
			if (expected_mix.size() == 0) begin
				$error("Result with none outstanding: mixed_value %0d", got.mixed_value);
				errors++;
				return;
			end
			want = expected_mix.pop_front();
			if (got.mixed_value !== want.mixed_value) begin
				$error("mixed_value: expected %0d, got %0d", want.mixed_value, got.mixed_value);
				errors++;
			end
			if (got.beyond_source !== want.beyond_source) begin
				$error("beyond_source: expected %0b, got %0b",
					want.beyond_source, got.beyond_source);
				errors++;
			end
			if (got.saturated !== want.saturated) begin
				$error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
				errors++;
			end
		endfunction
	endclass

	logic      clk, arst_n;
	logic      start, busy, done;
	cmd_t      cmd;
	rsp_t      rsp;
	logic      cfg_write;
	cfg_reg_t  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mix_scoreboard sb = new();
	int quiet_cycles;
	int n_settings;

	linear_interp_resample_mixer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.rsp       (rsp),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_rsp(rsp);
			if ((start && !busy) || done || cfg_write)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$error("Watchdog: no activity for %0d cycles", WATCHDOG_CYCLES);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	function automatic cmd_t load_cmd(logic [11:0] addr, logic [15:0] val);
		cmd_t c;
		c.mode           = MODE_LOAD;
		c.source_address = addr;
		c.sample_value   = val;
		c.output_index   = 16'($urandom);
		c.existing_value = 16'($urandom);
		return c;
	endfunction

	function automatic cmd_t compute_cmd(logic [15:0] idx, logic [15:0] existing);
		cmd_t c;
		c.mode           = MODE_COMPUTE;
		c.source_address = 12'($urandom);
		c.sample_value   = 16'($urandom);
		c.output_index   = idx;
		c.existing_value = existing;
		return c;
	endfunction

	task automatic send_cmd(cmd_t c, int idle_pct);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do
			@(posedge clk);
		while (busy);
		sb.note_cmd(c);
	endtask

	// block idle: nothing outstanding and the pipeline flushed of loads
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (sb.expected_mix.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [31:0] d);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= r;
		cfg_data  <= d;
		@(posedge clk);
		sb.set_reg(r, d);
	endtask

	task automatic set_config(logic [31:0] stp, int vc, int sc, int gn);
		logic [31:0] junk;
		junk = $urandom;
		write_reg(REG_POSITION_STEP, stp);
		write_reg(REG_VALID_COUNT, {junk[31:13], 13'(vc)});
		write_reg(REG_STORED_COUNT, {junk[18:0], 13'(sc)});
		write_reg(REG_MIX_GAIN, {junk[31:16], 16'(gn)});
		@(negedge clk);
		cfg_write <= 1'b0;
		n_settings++;
	endtask

	task automatic run_phase(logic [31:0] stp, int vc, int sc, int gn, int idle_pct,
			int n_items);
		longint top;
		logic [11:0] addr;
		settle();
		set_config(stp, vc, sc, gn);
		top = sb.usable_limit();
		if (sb.neighbour_bound() - 1 < top)
			top = sb.neighbour_bound() - 1;
		if (top > 47)
			top = 47;
		for (int a = 0; a <= top; a++)
			if (!sb.written[a])
				send_cmd(load_cmd(12'(a), 16'($urandom)), idle_pct);
		repeat (n_items) begin
			if ($urandom_range(0, 99) < 35) begin
				if ($urandom_range(0, 3) != 0 && sb.usable_limit() > 0)
					addr = 12'($urandom_range(0, int'(sb.usable_limit() > 4095 ? 4095
						: sb.usable_limit())));
				else
					addr = 12'($urandom_range(0, SOURCE_DEPTH - 1));
				send_cmd(load_cmd(addr, 16'($urandom)), idle_pct);
			end else begin
				send_cmd(compute_cmd(sb.pick_index(), 16'($urandom)), idle_pct);
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = '0;
		cfg_write = 1'b0;
		cfg_index = REG_POSITION_STEP;
		cfg_data  = '0;
		quiet_cycles = 0;
		n_settings   = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: nothing usable, everything passes through
		send_cmd(compute_cmd(16'd0, 16'sd1234), 0);
		send_cmd(compute_cmd(16'hFFFF, 16'h8000), 0);
		send_cmd(load_cmd(12'd0, 16'h7FFF), 0);
		send_cmd(load_cmd(12'd1, 16'h8000), 0);
		send_cmd(load_cmd(12'd2, 16'h0000), 0);
		send_cmd(load_cmd(12'd3, 16'hFFFF), 0);
		send_cmd(load_cmd(12'd4095, 16'h0001), 0);

		// half step: full-scale swing, floor on negative fraction, limit
		settle();
		set_config(32'h0000_8000, 3, 4, 16384);
		send_cmd(compute_cmd(16'd0, 16'h7FFF), 0);
		send_cmd(compute_cmd(16'd1, 16'h0000), 0);
		send_cmd(compute_cmd(16'd3, 16'h8000), 0);
		send_cmd(compute_cmd(16'd4, 16'h0000), 0);
		send_cmd(compute_cmd(16'd5, 16'h0000), 0);
		send_cmd(compute_cmd(16'd6, 16'h1234), 0);

		// minimum step, most negative gain
		settle();
		set_config(32'h0000_0001, 4096, 4, -32768);
		send_cmd(compute_cmd(16'hFFFF, 16'h0000), 0);
		send_cmd(compute_cmd(16'd0, 16'h8000), 0);

		run_phase(32'h0001_0000, 64, 64, 16384, 0, 160);
		run_phase(32'h0000_0001, 4096, 40, -32768, 63, 160);
		run_phase(32'h0000_0000, 30, 4096, 32767, 9, 150);
		run_phase(32'hFFFF_FFFF, 200, 200, $urandom_range(0, 65535), 0, 150);
		run_phase(32'h0001_8000, 3071, 120, -16384, 63, 160);
		run_phase($urandom_range(32'h2000, 32'h30000), 0, 50,
			$urandom_range(0, 65535), 9, 120);
		run_phase($urandom_range(32'h100, 32'h28000), 90, 3583,
			$urandom_range(0, 65535), 0, 160);
		run_phase($urandom_range(32'h100, 32'h40000), 150, 0,
			$urandom_range(0, 65535), 63, 120);
		run_phase($urandom, 130, 130, $urandom_range(0, 65535), 9, 160);
		run_phase($urandom_range(32'h400, 32'h20000), 180, 181,
			$urandom_range(0, 65535), 0, 110);
		settle();

		$display("Run covered %0d loads and %0d computes across %0d register settings,",
			sb.n_loads, sb.n_computes, n_settings);
		$display("of which %0d landed past the usable source and %0d clipped.",
			sb.n_beyond, sb.n_clipped);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
